// ===== rtl/core/brle_pkg.sv =====
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the byte/pair run-length expander.
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

  // configuration
  localparam int unsigned LimitW          = 19;
  localparam logic [LimitW-1:0] LimitReset = 19'h40000;

  // defaults for the top-level parameters
  localparam int unsigned BeatBytesDef      = 8;
  localparam int unsigned MaxOutputBytesDef = 262144;
  localparam int unsigned CmdDepthDef       = 4;

  // most beats one input item may produce
  localparam int unsigned MaxBeats = 64;

  // token codes
  localparam logic [7:0] TermByte = 8'hFF;
  localparam logic [7:0] TokRun   = 8'h00;
  localparam logic [7:0] TokPair  = 8'h01;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RUN,
    CMD_PAIR,
    CMD_STOP
  } cmd_op_e;

  // one decoded token handed from front to back
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] reps;
    logic       step_end;    // last command caused by this input byte
    logic       stream_end;  // the input byte carried the end-of-stream mark
  } cmd_t;

  typedef enum logic [1:0] {
    BK_FETCH,
    BK_EXEC,
    BK_CLOSE
  } bk_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/byte_rle_run_expander.sv =====
// ----------------------------------------------------------------------------
// byte_rle_run_expander
// Expands a byte stream of literals, byte runs and pair runs into beats.
// ----------------------------------------------------------------------------
//  channel   | handshake       | payload
//  ----------+-----------------+-------------------------------------------------
//  input     | push / full     | in_byte_i, in_last_i
//  result    | empty / pop     | out_bytes_o, out_count_o, out_beat_last_o,
//            |                 | out_finished_o
//  config    | cfg_we_i        | cfg_wdata_i (byte limit)
//
// The front takes one byte per cycle while the command queue has room; a byte
// with in_last_i holds full while the window drains.
// The back fetches a command, then expands it in slices of up to BeatBytes
// expanded bytes and hands on each full beat before the next slice; a literal
// or a byte that completes no token takes the fetch step and one slice step.
// No clearing pass after reset; the limit resets to 262144.
// Results sit in an output register, so a stalled reader only holds the back.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_rle_run_expander #(
  parameter int unsigned BeatBytes      = brle_pkg::BeatBytesDef,
  parameter int unsigned MaxOutputBytes = brle_pkg::MaxOutputBytesDef,
  parameter int unsigned CmdDepth       = brle_pkg::CmdDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte_i,
  input  logic                        in_last_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [63:0]                 out_bytes_o,
  output logic [3:0]                  out_count_o,
  output logic                        out_beat_last_o,
  output logic                        out_finished_o,
  input  logic                        cfg_we_i,
  input  logic [brle_pkg::LimitW-1:0] cfg_wdata_i
);
  import brle_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  brle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  brle_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  brle_back #(
    .BeatBytes      (BeatBytes),
    .MaxOutputBytes (MaxOutputBytes)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_empty_i     (cmd_empty),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .out_pop_i       (pop),
    .out_empty_o     (empty),
    .out_bytes_o     (out_bytes_o),
    .out_count_o     (out_count_o),
    .out_beat_last_o (out_beat_last_o),
    .out_finished_o  (out_finished_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/brle_front.sv =====
// ----------------------------------------------------------------------------
// brle_front
// Lookahead window and token classifier; queues one command per accepted byte or flush step.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output logic           cmd_push_o,
  output brle_pkg::cmd_t cmd_o,
  input  logic           cmd_full_i
);
  import brle_pkg::*;

  logic [3:0][7:0] win_q, win_d, src_w, win_after;
  logic [2:0]      fill_q, fill_d, src_f, fill_after, cons;
  logic            flush_q, flush_d;
  logic            accept, advance, end_mode, decode, term, clear, step_end;

  assign full_o     = flush_q | cmd_full_i;
  assign accept     = push_i & ~full_o;
  // while flushing, one window token leaves per cycle unless the command queue is full
  assign advance    = accept | (flush_q & ~cmd_full_i);
  assign cmd_push_o = advance;

  always_comb begin
    src_w = win_q;
    src_f = fill_q;
    if (!flush_q) begin
      src_w[fill_q[1:0]] = in_byte_i;
      src_f              = fill_q + 3'd1;
    end
  end

  assign end_mode = flush_q | in_last_i;
  assign decode   = end_mode | (src_f == 3'd4);
  assign term     = (src_f == 3'd4) && (src_w[0] == TermByte) && (src_w[1] == TermByte) &&
                    (src_w[2] == TermByte) && (src_w[3] == TermByte);

  always_comb begin
    cmd_o.op     = CMD_NONE;
    cmd_o.byte_a = src_w[0];
    cmd_o.byte_b = src_w[2];
    cmd_o.reps   = 8'd1;
    cons         = 3'd0;
    clear        = 1'b0;
    if (decode) begin
      priority if (term) begin
        cmd_o.op = CMD_STOP;
        clear    = 1'b1;
      end else if (src_w[0] == TokRun) begin
        if (src_f < 3'd3) begin
          clear = 1'b1;
        end else begin
          cmd_o.op     = CMD_RUN;
          cmd_o.byte_a = src_w[1];
          cmd_o.reps   = src_w[2];
          cons         = 3'd3;
        end
      end else if (src_w[0] == TokPair) begin
        if (src_f < 3'd4) begin
          clear = 1'b1;
        end else begin
          cmd_o.op     = CMD_PAIR;
          cmd_o.byte_a = src_w[1];
          cmd_o.byte_b = src_w[2];
          cmd_o.reps   = src_w[3];
          cons         = 3'd4;
        end
      end else begin
        // literal: a run of one
        cmd_o.op = CMD_RUN;
        cons     = 3'd1;
      end
    end
    cmd_o.stream_end = end_mode;
    // a truncated token drops the rest of the window
    cmd_o.step_end   = ~end_mode | clear | (src_f == cons);
  end

  assign fill_after = clear ? 3'd0 : (src_f - cons);
  assign win_after  = src_w >> {cons, 3'b000};
  assign step_end   = cmd_o.step_end;

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    flush_d = flush_q;
    if (advance) begin
      win_d   = win_after;
      fill_d  = fill_after;
      flush_d = end_mode & ~step_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      flush_q <= flush_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brle_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// brle_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_cmd_fifo #(
  parameter int unsigned Depth = brle_pkg::CmdDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brle_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output brle_pkg::cmd_t rdata_o,
  output logic           empty_o
);
  import brle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brle_back.sv =====
// ----------------------------------------------------------------------------
// brle_back
// Run expansion, beat packing, byte limit and stop handling.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_back #(
  parameter int unsigned BeatBytes      = brle_pkg::BeatBytesDef,
  parameter int unsigned MaxOutputBytes = brle_pkg::MaxOutputBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brle_pkg::LimitW-1:0]   cfg_wdata_i,
  input  logic                          cmd_empty_i,
  input  brle_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic                          out_pop_i,
  output logic                          out_empty_o,
  output logic [63:0]                   out_bytes_o,
  output logic [3:0]                    out_count_o,
  output logic                          out_beat_last_o,
  output logic                          out_finished_o
);
  import brle_pkg::*;

  localparam int unsigned Cap      = MaxBeats * BeatBytes;
  localparam int unsigned CapW     = $clog2(Cap + 1);
  localparam int unsigned LimTop   = (1 << LimitW) - 1;
  localparam int unsigned LimClamp = (MaxOutputBytes < LimTop) ? MaxOutputBytes : LimTop;
  localparam logic [LimitW-1:0] LimClampVal = LimitW'(LimClamp);
  localparam logic [CapW-1:0]   CapVal      = CapW'(Cap);
  localparam logic [3:0]        BeatCnt     = 4'(BeatBytes);

  bk_state_e         state_q, state_d;
  logic [LimitW-1:0] limit_q, written_q, written_d, eff_lim;
  logic              stopped_q, stopped_d, done_q, done_d;
  logic [8:0]        rem_q, rem_d;
  logic [7:0]        byte_a_q, byte_a_d, byte_b_q, byte_b_d;
  logic              pair_q, pair_d, phase_q, phase_d, tok_q, tok_d;
  logic              end_q, end_d, last_q, last_d;
  logic [63:0]       beat_q, beat_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [CapW-1:0]   stepcnt_q, stepcnt_d;

  logic [63:0]       out_bytes_q, out_bytes_d;
  logic [3:0]        out_count_q, out_count_d;
  logic              out_last_q, out_last_d, out_fin_q, out_fin_d, out_valid_q, out_valid_d;

  logic [LimitW-1:0] room_lim, written_post;
  logic [CapW-1:0]   room_cap;
  logic [3:0]        free, take, cnt_post;
  logic [8:0]        rem_after;
  logic [63:0]       beat_post;
  logic              act_drop, act_emit, act_take, lim_hit;
  logic              stop_fin, need_close, cmd_done, out_free, cmd_tok;

  assign eff_lim  = (limit_q > LimClampVal) ? LimClampVal : limit_q;
  assign out_free = ~out_valid_q | out_pop_i;
  assign cmd_tok  = (cmd_i.op == CMD_RUN) || (cmd_i.op == CMD_PAIR);

  // one slice of run expansion per cycle while the beat is not full, up to the free room of the beat
  always_comb begin
    logic [3:0] pos;
    pos      = '0;
    room_lim = eff_lim - written_q;
    room_cap = CapVal - stepcnt_q;
    free     = BeatCnt - cnt_q;
    act_drop = (rem_q != '0) && (room_cap == '0);
    act_emit = (rem_q != '0) && (room_cap != '0) && (cnt_q == BeatCnt);
    act_take = (rem_q != '0) && (room_cap != '0) && (cnt_q != BeatCnt);

    take = free;
    if (9'(take) > rem_q) begin
      take = rem_q[3:0];
    end
    if (LimitW'(take) > room_lim) begin
      take = room_lim[3:0];
    end
    if (CapW'(take) > room_cap) begin
      take = room_cap[3:0];
    end

    beat_post = beat_q;
    if (act_take) begin
      for (int p = 0; p < BeatBytes; p++) begin
        pos = 4'(p);
        if (pos >= cnt_q && pos < cnt_q + take) begin
          beat_post[8*p +: 8] = (pair_q && (phase_q ^ pos[0] ^ cnt_q[0])) ? byte_b_q
                                                                          : byte_a_q;
        end
      end
    end

    lim_hit      = act_take && (LimitW'(take) == room_lim);
    cnt_post     = act_take ? cnt_q + take : cnt_q;
    written_post = act_take ? written_q + LimitW'(take) : written_q;
    if (act_drop || lim_hit) begin
      rem_after = '0;
    end else if (act_take) begin
      rem_after = rem_q - 9'(take);
    end else begin
      rem_after = rem_q;
    end

    cmd_done   = (rem_after == '0);
    stop_fin   = stopped_q | lim_hit | (tok_q & (written_post >= eff_lim)) | (end_q & last_q);
    need_close = end_q & ((cnt_post != '0) | stop_fin);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_FETCH: begin
        if (!cmd_empty_i && !done_q) begin
          if (!stopped_q) begin
            state_d = BK_EXEC;
          end else if (cmd_i.step_end) begin
            state_d = BK_CLOSE;
          end
        end
      end
      BK_EXEC: begin
        if (cmd_done) begin
          state_d = (need_close && !out_free) ? BK_CLOSE : BK_FETCH;
        end
      end
      BK_CLOSE: begin
        if (out_free) begin
          state_d = BK_FETCH;
        end
      end
      default: state_d = BK_FETCH;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    written_d   = written_q;
    stopped_d   = stopped_q;
    done_d      = done_q;
    rem_d       = rem_q;
    byte_a_d    = byte_a_q;
    byte_b_d    = byte_b_q;
    pair_d      = pair_q;
    phase_d     = phase_q;
    tok_d       = tok_q;
    end_d       = end_q;
    last_d      = last_q;
    beat_d      = beat_q;
    cnt_d       = cnt_q;
    stepcnt_d   = stepcnt_q;
    out_bytes_d = out_bytes_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    out_fin_d   = out_fin_q;
    out_valid_d = out_valid_q & ~out_pop_i;

    unique case (state_q)
      BK_FETCH: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (!done_q) begin
            if (stopped_q) begin
              // rest of the stopping item is skipped
              if (cmd_i.step_end) begin
                stepcnt_d = '0;
              end
            end else begin
              byte_a_d = cmd_i.byte_a;
              byte_b_d = cmd_i.byte_b;
              pair_d   = (cmd_i.op == CMD_PAIR);
              phase_d  = 1'b0;
              tok_d    = cmd_tok;
              end_d    = cmd_i.step_end;
              last_d   = cmd_i.stream_end;
              unique case (cmd_i.op)
                CMD_RUN:  rem_d = {1'b0, cmd_i.reps};
                CMD_PAIR: rem_d = {cmd_i.reps, 1'b0};
                CMD_NONE: rem_d = '0;
                CMD_STOP: rem_d = '0;
              endcase
              if (cmd_i.op == CMD_STOP) begin
                stopped_d = 1'b1;
              end
              // limit check ahead of every token
              if (cmd_tok && (written_q >= eff_lim)) begin
                stopped_d = 1'b1;
                rem_d     = '0;
              end
            end
          end
        end
      end
      BK_EXEC: begin
        if (act_emit && out_free) begin
          out_bytes_d = beat_q;
          out_count_d = cnt_q;
          out_last_d  = 1'b0;
          out_fin_d   = 1'b0;
          out_valid_d = 1'b1;
          beat_d      = '0;
          cnt_d       = '0;
        end
        if (act_take) begin
          beat_d    = beat_post;
          cnt_d     = cnt_post;
          written_d = written_post;
          stepcnt_d = stepcnt_q + CapW'(take);
          phase_d   = phase_q ^ take[0];
        end
        rem_d = rem_after;
        if (cmd_done) begin
          stopped_d = stop_fin;
          if (end_q) begin
            stepcnt_d = '0;
            if (need_close && out_free) begin
              out_bytes_d = beat_post;
              out_count_d = cnt_post;
              out_last_d  = 1'b1;
              out_fin_d   = stop_fin;
              out_valid_d = 1'b1;
              beat_d      = '0;
              cnt_d       = '0;
              done_d      = stop_fin;
            end
          end
        end
      end
      BK_CLOSE: begin
        if (out_free) begin
          out_bytes_d = beat_q;
          out_count_d = cnt_q;
          out_last_d  = 1'b1;
          out_fin_d   = stopped_q;
          out_valid_d = 1'b1;
          beat_d      = '0;
          cnt_d       = '0;
          done_d      = stopped_q;
        end
      end
      default: ;
    endcase
  end

  assign out_empty_o     = ~out_valid_q;
  assign out_bytes_o     = out_bytes_q;
  assign out_count_o     = out_count_q;
  assign out_beat_last_o = out_last_q;
  assign out_finished_o  = out_fin_q;

  always_ff @(posedge clk_i) begin
    byte_a_q    <= byte_a_d;
    byte_b_q    <= byte_b_d;
    pair_q      <= pair_d;
    phase_q     <= phase_d;
    tok_q       <= tok_d;
    end_q       <= end_d;
    last_q      <= last_d;
    out_bytes_q <= out_bytes_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
    out_fin_q   <= out_fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_FETCH;
      limit_q     <= LimitReset;
      written_q   <= '0;
      stopped_q   <= 1'b0;
      done_q      <= 1'b0;
      rem_q       <= '0;
      beat_q      <= '0;
      cnt_q       <= '0;
      stepcnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= cfg_we_i ? cfg_wdata_i : limit_q;
      written_q   <= written_d;
      stopped_q   <= stopped_d;
      done_q      <= done_d;
      rem_q       <= rem_d;
      beat_q      <= beat_d;
      cnt_q       <= cnt_d;
      stepcnt_q   <= stepcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brle_checker.sv =====
// ----------------------------------------------------------------------------
// brle_checker
// Port-level checks on the result channel of the run expander.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_checker #(
  parameter int unsigned BeatBytes = brle_pkg::BeatBytesDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [63:0] out_bytes_o,
  input logic [3:0]  out_count_o,
  input logic        out_beat_last_o,
  input logic        out_finished_o
);

  localparam logic [3:0] BeatCnt = 4'(BeatBytes);

  logic fin_seen_q, fin_seen_d;

  // decoding has ended once a finishing beat is transferred
  assign fin_seen_d = fin_seen_q | (pop & ~empty & out_finished_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_seen_q <= 1'b0;
    end else begin
      fin_seen_q <= fin_seen_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_count_o <= BeatCnt)
    else $error("beat count above beat size");

  a_inner_beat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_beat_last_o) |-> out_count_o == BeatCnt)
    else $error("beat before the last one is not full");

  a_finish_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_finished_o) |-> out_beat_last_o)
    else $error("finished flag off the last beat");

  a_silent_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_seen_q |-> empty)
    else $error("result after decoding ended");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_bytes_o) && $stable(out_count_o) &&
                          $stable(out_beat_last_o) && $stable(out_finished_o)))
    else $error("waiting result changed");

endmodule

bind byte_rle_run_expander brle_checker #(
  .BeatBytes (BeatBytes)
) u_brle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .out_bytes_o     (out_bytes_o),
  .out_count_o     (out_count_o),
  .out_beat_last_o (out_beat_last_o),
  .out_finished_o  (out_finished_o)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte/pair run-length expander. Compressed bytes
// go in through a bursty queue-style driver. A predictor works out the beats
// each accepted byte should cause. A stalling monitor compares every beat
// field by field. The byte limit is moved between phases, and the run ends on
// a terminator, a flush, a clamp or a limit already reached.
// ----------------------------------------------------------------------------
module tb_top;
  import brle_pkg::*;

  localparam int unsigned BeatW        = BeatBytesDef;
  localparam int unsigned ByteCap      = MaxBeats * BeatBytesDef;
  localparam int unsigned SettleCycles = 100;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        beat_last;
    logic        finished;
  } beat_t;

  typedef enum int {
    END_TERM,
    END_FLUSH,
    END_CLAMP,
    END_AT_LIMIT
  } end_mode_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  logic              full;
  logic [7:0]        in_byte_i   = '0;
  logic              in_last_i   = 1'b0;
  logic              empty;
  logic              pop         = 1'b0;
  logic [63:0]       out_bytes_o;
  logic [3:0]        out_count_o;
  logic              out_beat_last_o;
  logic              out_finished_o;
  logic              cfg_we_i    = 1'b0;
  logic [LimitW-1:0] cfg_wdata_i = '0;

  byte_rle_run_expander dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .empty          (empty),
    .pop            (pop),
    .out_bytes_o    (out_bytes_o),
    .out_count_o    (out_count_o),
    .out_beat_last_o(out_beat_last_o),
    .out_finished_o (out_finished_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("byte_rle_run_expander: mismatch");
    $finish;
  end

  // expander model state
  logic [7:0]        win [4];
  int unsigned       win_fill  = 0;
  int unsigned       written   = 0;
  logic              halted    = 1'b0;
  logic [LimitW-1:0] limit_reg = LimitReset;
  logic [7:0]        step_bytes [$];
  beat_t             beats_due [$];
  in_item_t          pending [$];

  function automatic int unsigned limit_eff();
    int unsigned lim;
    lim = limit_reg;
    if (lim > MaxOutputBytesDef) lim = MaxOutputBytesDef;
    return lim;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    if (written >= limit_eff()) return;
    if (step_bytes.size() < ByteCap) begin
      step_bytes.push_back(b);
      written++;
    end
  endfunction

  function automatic void drop_front(input int unsigned n);
    if (n >= win_fill) begin
      win_fill = 0;
      return;
    end
    for (int i = 0; i < win_fill - n; i++) win[i] = win[i + n];
    win_fill -= n;
  endfunction

  function automatic void decode_token();
    int unsigned lim;
    int unsigned reps;
    lim = limit_eff();
    if (written >= lim) begin
      halted = 1'b1;
      return;
    end
    if (win_fill == 4 && win[0] == TermByte && win[1] == TermByte &&
        win[2] == TermByte && win[3] == TermByte) begin
      halted = 1'b1;
      return;
    end
    if (win[0] == TokRun) begin
      // a token cut short by the end of input is thrown away
      if (win_fill < 3) begin
        win_fill = 0;
        return;
      end
      reps = win[2];
      repeat (reps) emit_byte(win[1]);
      drop_front(3);
    end else if (win[0] == TokPair) begin
      if (win_fill < 4) begin
        win_fill = 0;
        return;
      end
      reps = win[3];
      repeat (reps) begin
        emit_byte(win[1]);
        emit_byte(win[2]);
      end
      drop_front(4);
    end else begin
      emit_byte(win[0]);
      drop_front(1);
    end
    if (written >= lim) halted = 1'b1;
  endfunction

  function automatic void predict_beats(input logic [7:0] b, input logic last);
    int unsigned nbeats;
    int unsigned cnt;
    beat_t       beat;
    if (halted) return;
    step_bytes.delete();
    if (win_fill > 3) drop_front(1);
    win[win_fill & 3] = b;
    win_fill++;
    if (last) begin
      while (!halted && win_fill > 0) decode_token();
      halted = 1'b1;
    end else if (win_fill == 4) begin
      decode_token();
    end
    nbeats = (step_bytes.size() + BeatW - 1) / BeatW;
    if (nbeats == 0) begin
      // stopping with nothing to send still gives one empty beat
      if (halted) begin
        beat = '{bytes: '0, count: '0, beat_last: 1'b1, finished: 1'b1};
        beats_due.push_back(beat);
      end
      return;
    end
    for (int k = 0; k < nbeats; k++) begin
      cnt = step_bytes.size() - k * BeatW;
      if (cnt > BeatW) cnt = BeatW;
      beat.bytes = '0;
      for (int j = 0; j < cnt; j++) beat.bytes[8*j +: 8] = step_bytes[k * BeatW + j];
      beat.count     = cnt[3:0];
      beat.beat_last = (k + 1 == nbeats);
      beat.finished  = (k + 1 == nbeats) && halted;
      beats_due.push_back(beat);
    end
  endfunction

  // stimulus generation
  logic        ff_guard     = 1'b1;
  int unsigned ff_streak    = 0;
  int unsigned queued_items = 0;

  function automatic void add_byte(input logic [7:0] b, input logic last = 1'b0);
    in_item_t it;
    // keep four 0xff in a row out of the stream unless a terminator is wanted
    if (ff_guard && b == TermByte && ff_streak == 3) b = 8'hFE;
    ff_streak = (b == TermByte) ? ff_streak + 1 : 0;
    it.data = b;
    it.last = last;
    pending.push_back(it);
    queued_items++;
  endfunction

  function automatic logic [7:0] rand_reps();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return 8'($urandom_range(0, 12));
    if (pick < 95) return 8'($urandom_range(13, 64));
    return 8'($urandom_range(65, 255));
  endfunction

  function automatic void add_token(input bit noise_ok);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      add_byte(8'($urandom_range(2, 255)));
    end else if (pick < 70) begin
      add_byte(TokRun);
      add_byte(8'($urandom()));
      add_byte(rand_reps());
    end else if (pick < 90 || !noise_ok) begin
      add_byte(TokPair);
      add_byte(8'($urandom()));
      add_byte(8'($urandom()));
      add_byte(rand_reps());
    end else begin
      // raw bytes, often breaking up the token structure
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom()));
    end
  endfunction

  function automatic void fill_random(input int unsigned n);
    int unsigned mark;
    mark = queued_items;
    while (queued_items - mark < n) add_token(1'b1);
  endfunction

  task automatic settle();
    @(negedge clk_i);
    while (pending.size() != 0 || push) @(negedge clk_i);
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg = value;
  endtask

  // driver: bursts of transfers with random gaps
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned items_taken = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_byte_i <= '0;
      in_last_i <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_beats(in_byte_i, in_last_i);
        void'(pending.pop_front());
        items_taken++;
      end
      if (!(push && full)) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending.size() != 0) begin
          push      <= 1'b1;
          in_byte_i <= pending[0].data;
          in_last_i <= pending[0].last;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pops with random stalls; the stall mode is redrawn at random
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_timer = 0;
  int unsigned beats_seen = 0;
  int unsigned failures   = 0;
  beat_t       want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beats_seen++;
        if (beats_due.size() == 0) begin
          $error("unexpected beat: out_bytes %h out_count %0d", out_bytes_o, out_count_o);
          failures++;
        end else begin
          want = beats_due.pop_front();
          if (out_bytes_o !== want.bytes) begin
            $error("out_bytes: expected %h, got %h", want.bytes, out_bytes_o);
            failures++;
          end
          if (out_count_o !== want.count) begin
            $error("out_count: expected %0d, got %0d", want.count, out_count_o);
            failures++;
          end
          if (out_beat_last_o !== want.beat_last) begin
            $error("out_beat_last: expected %b, got %b", want.beat_last, out_beat_last_o);
            failures++;
          end
          if (out_finished_o !== want.finished) begin
            $error("out_finished: expected %b, got %b", want.finished, out_finished_o);
            failures++;
          end
        end
      end
      mode_timer++;
      if (mode_timer == 256) begin
        mode_timer = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (stall_mode != 0 && $urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, (stall_mode == 1) ? 2 : 24);
      end
    end
  end

  initial begin
    end_mode_e finish_how;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, run under the reset limit
    add_byte(8'h02);
    add_byte(8'hFE);
    add_byte(TokRun);  add_byte(8'h00); add_byte(8'h00);
    add_byte(TokRun);  add_byte(8'hFF); add_byte(8'hFF);
    add_byte(TokPair); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h01);
    add_byte(TokPair); add_byte(8'hAA); add_byte(8'h55); add_byte(8'hFF);
    // three 0xff literals that fall one short of a terminator
    add_byte(8'h80);
    add_byte(TermByte); add_byte(TermByte); add_byte(TermByte);
    add_byte(8'h02);
    add_byte(TokRun);  add_byte(8'h7F); add_byte(8'h01);
    settle();

    // above the maximum, so it clamps
    write_limit('1);
    fill_random(95);
    settle();
    write_limit(LimitW'(written + $urandom_range(40000, 100000)));
    fill_random(95);
    settle();
    write_limit(LimitW'(MaxOutputBytesDef));
    fill_random(95);
    settle();

    finish_how = end_mode_e'($urandom_range(0, 3));
    case (finish_how)
      END_TERM: begin
        repeat (3) add_token(1'b0);
        ff_guard = 1'b0;
        repeat (4) add_byte(TermByte);
      end
      END_FLUSH: begin
        repeat (2) add_token(1'b0);
        case ($urandom_range(0, 4))
          0: begin
            add_byte(TokRun);
            add_byte(8'($urandom()), 1'b1);
          end
          1: begin
            add_byte(TokPair);
            add_byte(8'($urandom()));
            add_byte(8'($urandom()), 1'b1);
          end
          2: begin
            add_byte(TokPair);
            add_byte(8'($urandom()), 1'b1);
          end
          3: add_byte(8'($urandom_range(2, 254)), 1'b1);
          default: begin
            add_byte(TokRun);
            add_byte(8'($urandom()));
            add_byte(rand_reps(), 1'b1);
          end
        endcase
      end
      END_CLAMP: begin
        write_limit(LimitW'(written + $urandom_range(1, 40)));
        repeat (6) begin
          add_byte(TokRun);
          add_byte(8'($urandom()));
          add_byte(8'($urandom_range(8, 40)));
        end
      end
      default: begin
        // the limit is already reached, so the next token stops decoding
        write_limit(LimitW'(written));
        repeat (4) add_byte(8'($urandom_range(2, 254)));
      end
    endcase

    // bytes after the stop must be dropped without a result
    add_byte(8'($urandom()), 1'b0);
    add_byte(8'($urandom()), 1'b1);
    add_byte(8'($urandom()), 1'b0);
    add_byte(8'($urandom()), 1'b1);
    settle();
    write_limit('0);
    add_byte(8'($urandom()));
    add_byte(8'($urandom()));
    settle();

    $display("run covered %0d input bytes and %0d output beats, ended by %s",
             items_taken, beats_seen, finish_how.name());
    if (failures == 0) begin
      $display("byte_rle_run_expander: match");
    end else begin
      $display("byte_rle_run_expander: mismatch");
    end
    $finish;
  end

endmodule
